// ----- rtl/core/lobt_pkg.sv -----
// ----------------------------------------------------------------------------
// Limit order book table package
// Shared constants, codes, item types and the scan result record.
// ----------------------------------------------------------------------------
package lobt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 7;

    localparam logic [1:0] OTYPE_IOC = 2'd0;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_MODIFY = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        STAT_CREATED       = 4'd0,
        STAT_IOC           = 4'd1,
        STAT_DUP           = 4'd2,
        STAT_MOD_MISSING   = 4'd3,
        STAT_PRICE_DIFF    = 4'd4,
        STAT_QTY_NOT_LOWER = 4'd5,
        STAT_MODIFIED      = 4'd6,
        STAT_DEL_MISSING   = 4'd7,
        STAT_DELETED       = 4'd8,
        STAT_CLEARED       = 4'd9,
        STAT_FULL          = 4'd10
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic        side;
        logic [31:0] key_id;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [1:0]  order_type;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic             bid_present;
        logic [31:0]      best_bid;
        logic             ask_present;
        logic [31:0]      best_ask;
        logic [CNT_W-1:0] bids_removed;
        logic [CNT_W-1:0] asks_removed;
    } t_out_item;

    typedef struct packed {
        logic        side;
        logic [31:0] key_id;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [31:0]      hit_price;
        logic [31:0]      hit_qty;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic             bid_have;
        logic [31:0]      best_bid;
        logic             ask_have;
        logic [31:0]      best_ask;
    } t_scan_res;

endpackage

// ----- rtl/core/lobt_scan.sv -----
// ----------------------------------------------------------------------------
// Limit order book table scan unit
// Looks at one table entry per cycle while i_step is high and folds it into
// the key match, the lowest free entry and the best bid and ask seen so far.
// ----------------------------------------------------------------------------
module lobt_scan import lobt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_step,
    input  t_entry           i_entry,
    input  logic             i_entry_valid,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_key_side,
    input  logic [31:0]      i_key_id,
    input  logic             i_drop_hit,
    output t_scan_res        o_res
);

    t_scan_res r_res;
    logic      match;
    logic      counted;

    // An entry that a delete is about to remove does not count toward the best prices.
    assign match   = i_entry_valid && (i_entry.side == i_key_side)
                     && (i_entry.key_id == i_key_id);
    assign counted = i_entry_valid && !(i_drop_hit && match);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.hit      <= 1'b0;
            r_res.free_ok  <= 1'b0;
            r_res.bid_have <= 1'b0;
            r_res.ask_have <= 1'b0;
        end else if (i_start) begin
            r_res.hit      <= 1'b0;
            r_res.free_ok  <= 1'b0;
            r_res.bid_have <= 1'b0;
            r_res.ask_have <= 1'b0;
            r_res.best_bid <= '0;
            r_res.best_ask <= '1;
        end else if (i_step) begin
            if (match) begin
                r_res.hit       <= 1'b1;
                r_res.hit_idx   <= i_idx;
                r_res.hit_price <= i_entry.price;
                r_res.hit_qty   <= i_entry.quantity;
            end
            if (!i_entry_valid && !r_res.free_ok) begin
                r_res.free_ok  <= 1'b1;
                r_res.free_idx <= i_idx;
            end
            if (counted && i_entry.side) begin
                r_res.bid_have <= 1'b1;
                if (!r_res.bid_have || (i_entry.price > r_res.best_bid)) begin
                    r_res.best_bid <= i_entry.price;
                end
            end
            if (counted && !i_entry.side) begin
                r_res.ask_have <= 1'b1;
                if (!r_res.ask_have || (i_entry.price < r_res.best_ask)) begin
                    r_res.best_ask <= i_entry.price;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/limit_order_book_table_core.sv -----
// ----------------------------------------------------------------------------
// Limit order book table core
// Resting order table with create, modify, delete and clear actions.
// ----------------------------------------------------------------------------
// Usage: an action item enters on i_data when i_valid is high and o_stall is
// low. Each action yields exactly one result item on o_data, qualified by
// o_valid and held while i_stall is high. A result carries the status code
// and the best bid and best ask as they stand after the action.
// The block works on one action at a time. The pace is set by the table
// memory, whose single read port feeds the scan unit one entry per cycle;
// the block holds o_stall high for the whole scan and takes the next item
// once its current action has been written back.
// The result sits in an output register, so the next item may be accepted
// while the previous result still waits. A new action only commits once the
// output register is free, so a stalling receiver stalls the block.
// Reset clears the entry valid bits, both side counts and the handshakes;
// the table memory itself is not cleared; entries never written are read
// too, but the scan ignores them because their valid bits are clear.
// ----------------------------------------------------------------------------
module limit_order_book_table_core import lobt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    // Sequencer state and the item under work.
    t_state           r_state;
    t_state           n_state;
    t_in_item         r_item;
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] n_addr;

    // Table: valid bits in flops, payload in a memory with one read and one write port.
    logic [CAPACITY-1:0] r_valid;
    t_entry              r_mem [CAPACITY];
    t_entry              r_rd_entry;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_rd_go;

    logic [CNT_W-1:0] r_bid_count;
    logic [CNT_W-1:0] r_ask_count;

    t_out_item r_out;
    logic      r_out_valid;

    t_scan_res scan_res;

    logic accept;
    logic scan_rd;
    logic commit_fire;
    logic last_addr;

    // Commit decision.
    t_status          c_status;
    logic             c_write;
    logic [IDX_W-1:0] c_widx;
    logic             c_set_valid;
    logic             c_clr_valid;
    logic             c_clear_all;
    t_out_item        c_out;

    assign last_addr = (r_addr == IDX_W'(CAPACITY - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_addr) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall     = 1'b1;
        scan_rd     = 1'b0;
        commit_fire = 1'b0;
        n_addr      = r_addr;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                n_addr  = '0;
            end
            ST_SCAN: begin
                scan_rd = 1'b1;
                n_addr  = r_addr + 1'b1;
            end
            ST_LAST: begin
                n_addr = r_addr;
            end
            ST_COMMIT: begin
                commit_fire = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_rd_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rd_go <= scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
        end
    end

    // Memory read and write ports. The valid bit travels with the read data.
    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_mem[r_addr];
        r_rd_vld   <= r_valid[r_addr];
        r_rd_idx   <= r_addr;
        if (commit_fire && c_write) begin
            r_mem[c_widx] <= '{side:     r_item.side,
                               key_id:   r_item.key_id,
                               price:    r_item.price,
                               quantity: r_item.quantity};
        end
    end

    lobt_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_step        (r_rd_go),
        .i_entry       (r_rd_entry),
        .i_entry_valid (r_rd_vld),
        .i_idx         (r_rd_idx),
        .i_key_side    (r_item.side),
        .i_key_id      (r_item.key_id),
        .i_drop_hit    (r_item.mode == MODE_DELETE),
        .o_res         (scan_res)
    );

    // Decide the action from the finished scan. A successful create folds
    // the new price into the best prices; a delete was already left out of
    // them by the scan unit.
    always_comb begin
        c_status    = STAT_CLEARED;
        c_write     = 1'b0;
        c_widx      = scan_res.hit_idx;
        c_set_valid = 1'b0;
        c_clr_valid = 1'b0;
        c_clear_all = 1'b0;

        c_out.bid_present  = scan_res.bid_have;
        c_out.best_bid     = scan_res.best_bid;
        c_out.ask_present  = scan_res.ask_have;
        c_out.best_ask     = scan_res.best_ask;
        c_out.bids_removed = '0;
        c_out.asks_removed = '0;

        unique case (r_item.mode)
            MODE_CREATE: begin
                priority if (r_item.order_type == OTYPE_IOC) begin
                    c_status = STAT_IOC;
                end else if (scan_res.hit) begin
                    c_status = STAT_DUP;
                end else if (!scan_res.free_ok) begin
                    c_status = STAT_FULL;
                end else begin
                    c_status    = STAT_CREATED;
                    c_write     = 1'b1;
                    c_widx      = scan_res.free_idx;
                    c_set_valid = 1'b1;
                    if (r_item.side) begin
                        c_out.bid_present = 1'b1;
                        if (!scan_res.bid_have || (r_item.price > scan_res.best_bid)) begin
                            c_out.best_bid = r_item.price;
                        end
                    end else begin
                        c_out.ask_present = 1'b1;
                        if (!scan_res.ask_have || (r_item.price < scan_res.best_ask)) begin
                            c_out.best_ask = r_item.price;
                        end
                    end
                end
            end
            MODE_MODIFY: begin
                priority if (!scan_res.hit) begin
                    c_status = STAT_MOD_MISSING;
                end else if (scan_res.hit_price != r_item.price) begin
                    c_status = STAT_PRICE_DIFF;
                end else if (scan_res.hit_qty <= r_item.quantity) begin
                    c_status = STAT_QTY_NOT_LOWER;
                end else begin
                    c_status = STAT_MODIFIED;
                    c_write  = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (scan_res.hit) begin
                    c_status    = STAT_DELETED;
                    c_clr_valid = 1'b1;
                end else begin
                    c_status = STAT_DEL_MISSING;
                end
            end
            MODE_CLEAR: begin
                c_status           = STAT_CLEARED;
                c_clear_all        = 1'b1;
                c_out.bid_present  = 1'b0;
                c_out.best_bid     = '0;
                c_out.ask_present  = 1'b0;
                c_out.best_ask     = '1;
                c_out.bids_removed = r_bid_count;
                c_out.asks_removed = r_ask_count;
            end
            default: begin
                c_status = STAT_CLEARED;
            end
        endcase
        c_out.status = c_status;
    end

    // Valid bits and side counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_bid_count <= '0;
            r_ask_count <= '0;
        end else if (commit_fire) begin
            if (c_clear_all) begin
                r_valid     <= '0;
                r_bid_count <= '0;
                r_ask_count <= '0;
            end else if (c_set_valid) begin
                r_valid[c_widx] <= 1'b1;
                if (r_item.side) begin
                    r_bid_count <= r_bid_count + 1'b1;
                end else begin
                    r_ask_count <= r_ask_count + 1'b1;
                end
            end else if (c_clr_valid) begin
                r_valid[c_widx] <= 1'b0;
                if (r_item.side) begin
                    r_bid_count <= r_bid_count - 1'b1;
                end else begin
                    r_ask_count <= r_ask_count - 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_out <= c_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // The scan address walks the table one entry per cycle.
    a_scan_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && !last_addr |=>
            (r_state == ST_SCAN) && (r_addr == $past(r_addr) + 1'b1))
        else $error("scan address did not advance");

    // A created order occupies the entry it was written to.
    a_create_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_fire && c_set_valid |=> r_valid[$past(c_widx)])
        else $error("created entry not marked valid");

    // A pending result that is stalled holds back the next commit.
    a_commit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) && r_out_valid && i_stall |=>
            (r_state == ST_COMMIT) && $stable(r_out))
        else $error("commit overran a stalled result");

endmodule

// ----- tb/sv/limit_order_book_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// Limit order book table core testbench
// Drives create, modify, delete and clear actions into the order table and
// checks every result item against a behavioral copy of the book kept here:
// status code, best bid and best ask with their presence flags, and the
// removed counts of a clear. A directed opening covers the field extremes and
// every status code but STAT_FULL; then random traffic: mostly well-formed actions
// on resting orders plus table fills and noise, under random idling on both sides.
// ----------------------------------------------------------------------------
module limit_order_book_table_core_tb;
    import lobt_pkg::*;

    // Action item waiting to be offered. When wait_empty is set the sender
    // holds the item back until every outstanding result has arrived.
    typedef struct {
        t_in_item item;
        bit       wait_empty;
    } t_pending;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    limit_order_book_table_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Book as the block should hold it, advanced on each accepted item.
    logic     book_valid [CAPACITY];
    t_entry   book_entry [CAPACITY];
    // Book as the stimulus generator sees it, so that modifies and deletes
    // can target orders that will really be resting when they arrive.
    logic     plan_valid [CAPACITY];
    t_entry   plan_entry [CAPACITY];

    t_pending  action_q [$];
    t_out_item report_q [$];

    int n_planned  = 0;
    bit drain_due  = 1'b0;
    int n_fail     = 0;
    int n_results  = 0;

    // Sender and receiver pacing state.
    int burst_left;
    int gap_left;
    bit still_offered;
    t_pending next_action;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int phase_left = 0;
    int stall_pct  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Applies one action to a book and returns the result item it yields.
    // The key search, the lowest free entry and the side counts all come
    // from the book as it stands before the action; the best prices are
    // taken from the book as it stands after it.
    function automatic t_out_item book_apply(ref logic vld [CAPACITY],
                                             ref t_entry ent [CAPACITY],
                                             input t_in_item act);
        t_out_item res;
        int hit;
        int slot;
        int n_bid;
        int n_ask;
        res          = '0;
        res.best_ask = '1;
        hit   = -1;
        slot  = -1;
        n_bid = 0;
        n_ask = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (vld[i] && hit < 0 && ent[i].side == act.side
                    && ent[i].key_id == act.key_id)
                hit = i;
            if (!vld[i] && slot < 0)
                slot = i;
            if (vld[i]) begin
                if (ent[i].side)
                    n_bid++;
                else
                    n_ask++;
            end
        end
        case (act.mode)
            MODE_CREATE: begin
                // Immediate-or-cancel is refused first, then a duplicate key,
                // and only then a full table.
                if (act.order_type == OTYPE_IOC) begin
                    res.status = STAT_IOC;
                end else if (hit >= 0) begin
                    res.status = STAT_DUP;
                end else if (slot < 0) begin
                    res.status = STAT_FULL;
                end else begin
                    vld[slot]          = 1'b1;
                    ent[slot].side     = act.side;
                    ent[slot].key_id   = act.key_id;
                    ent[slot].price    = act.price;
                    ent[slot].quantity = act.quantity;
                    res.status         = STAT_CREATED;
                end
            end
            MODE_MODIFY: begin
                if (hit < 0) begin
                    res.status = STAT_MOD_MISSING;
                end else if (ent[hit].price != act.price) begin
                    res.status = STAT_PRICE_DIFF;
                end else if (ent[hit].quantity <= act.quantity) begin
                    res.status = STAT_QTY_NOT_LOWER;
                end else begin
                    ent[hit].quantity = act.quantity;
                    res.status        = STAT_MODIFIED;
                end
            end
            MODE_DELETE: begin
                if (hit < 0) begin
                    res.status = STAT_DEL_MISSING;
                end else begin
                    vld[hit]   = 1'b0;
                    res.status = STAT_DELETED;
                end
            end
            default: begin
                res.bids_removed = CNT_W'(n_bid);
                res.asks_removed = CNT_W'(n_ask);
                for (int i = 0; i < CAPACITY; i++)
                    vld[i] = 1'b0;
                res.status = STAT_CLEARED;
            end
        endcase
        for (int i = 0; i < CAPACITY; i++) begin
            if (vld[i]) begin
                if (ent[i].side) begin
                    if (!res.bid_present || ent[i].price > res.best_bid)
                        res.best_bid = ent[i].price;
                    res.bid_present = 1'b1;
                end else begin
                    if (!res.ask_present || ent[i].price < res.best_ask)
                        res.best_ask = ent[i].price;
                    res.ask_present = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Queues one action and advances the planning book with it.
    task automatic plan_action(input t_mode m, input logic sd, input logic [31:0] id,
                               input logic [31:0] pr, input logic [31:0] qt,
                               input logic [1:0] ot);
        t_pending p;
        p.item.mode       = m;
        p.item.side       = sd;
        p.item.key_id     = id;
        p.item.price      = pr;
        p.item.quantity   = qt;
        p.item.order_type = ot;
        p.wait_empty      = drain_due;
        drain_due         = 1'b0;
        void'(book_apply(plan_valid, plan_entry, p.item));
        action_q.push_back(p);
        n_planned++;
    endtask

    // Picks a random order that will be resting when the next queued action
    // reaches the block. Returns 0 when the planned book is empty.
    function automatic bit pick_resting(output logic sd, output logic [31:0] id,
                                        output logic [31:0] pr,
                                        output logic [31:0] qt);
        int idx [$];
        int k;
        sd = 1'b0;
        id = '0;
        pr = '0;
        qt = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (plan_valid[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return 1'b0;
        k  = idx[$urandom_range(0, idx.size() - 1)];
        sd = plan_entry[k].side;
        id = plan_entry[k].key_id;
        pr = plan_entry[k].price;
        qt = plan_entry[k].quantity;
        return 1'b1;
    endfunction

    // Order ids come mostly from a small pool so that keys collide often.
    function automatic logic [31:0] rand_id();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] rand_rest_type();
        return 2'($urandom_range(1, 3));
    endfunction

    // Compares one field of a result item and reports the first mismatches.
    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_fail++;
            if (n_fail <= 10)
                $display("mismatch in result %0d, %s: expected %0h, got %0h",
                         n_results, fname, want, got);
        end
    endtask

    // Stimulus generation and the end of the run.
    initial begin
        logic        sd;
        logic [31:0] id;
        logic [31:0] pr;
        logic [31:0] qt;
        int          r;

        for (int i = 0; i < CAPACITY; i++)
            plan_valid[i] = 1'b0;

        // Directed opening: clear on an empty book, every create outcome
        // except a full table, each modify and delete outcome, both sides
        // sharing one id, the extremes of id, price and quantity, the unused
        // order type, and a clear that removes orders from both sides.
        plan_action(MODE_CLEAR,  1'b1, 32'h0,         32'h0,         32'h0,         2'd3);
        plan_action(MODE_CREATE, 1'b1, 32'd5,         32'd100,       32'd10,        OTYPE_IOC);
        plan_action(MODE_CREATE, 1'b1, 32'h0,         32'h0,         32'hFFFF_FFFF, 2'd1);
        plan_action(MODE_CREATE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         2'd2);
        plan_action(MODE_CREATE, 1'b1, 32'hFFFF_FFFF, 32'd1000,      32'd50,        2'd3);
        plan_action(MODE_CREATE, 1'b0, 32'h0,         32'd7,         32'd100,       2'd2);
        plan_action(MODE_CREATE, 1'b1, 32'h0,         32'd9,         32'd9,         2'd2);
        plan_action(MODE_CREATE, 1'b1, 32'h0,         32'd9,         32'd9,         OTYPE_IOC);
        plan_action(MODE_MODIFY, 1'b1, 32'd12345,     32'd0,         32'd0,         2'd1);
        plan_action(MODE_MODIFY, 1'b0, 32'h0,         32'd8,         32'd1,         2'd2);
        plan_action(MODE_MODIFY, 1'b0, 32'h0,         32'd7,         32'd100,       2'd2);
        plan_action(MODE_MODIFY, 1'b0, 32'h0,         32'd7,         32'd99,        OTYPE_IOC);
        plan_action(MODE_MODIFY, 1'b1, 32'h0,         32'h0,         32'hFFFF_FFFE, OTYPE_IOC);
        plan_action(MODE_MODIFY, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         2'd3);
        plan_action(MODE_DELETE, 1'b0, 32'd5,         32'd0,         32'd0,         2'd0);
        plan_action(MODE_DELETE, 1'b1, 32'hFFFF_FFFF, 32'h0,         32'h0,         2'd3);
        plan_action(MODE_DELETE, 1'b1, 32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1);
        plan_action(MODE_CREATE, 1'b1, 32'd77,        32'hAAAA_AAAA, 32'h5555_5555, 2'd2);
        plan_action(MODE_CREATE, 1'b1, 32'd78,        32'h5555_5555, 32'hAAAA_AAAA, 2'd1);
        plan_action(MODE_DELETE, 1'b0, 32'd77,        32'h0,         32'h0,         2'd2);
        plan_action(MODE_CLEAR,  1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0);
        plan_action(MODE_CLEAR,  1'b1, 32'd1,         32'd1,         32'd1,         2'd2);

        // Random part. Most actions are well formed against the planned book;
        // a few table fills push the block into the full-table case.
        while (n_planned < 920) begin
            if (n_planned >= 470 && n_planned < 480)
                drain_due = 1'b1;
            r = $urandom_range(0, 99);
            if (n_planned == 250 || n_planned == 600 || $urandom_range(0, 299) == 0) begin
                // Fill the table from empty, then probe it while it is full:
                // three creates too many, an ioc and a duplicate on the full
                // table, and a delete that frees one entry for a new create.
                plan_action(MODE_CLEAR, 1'($urandom), rand_id(), rand_word(),
                            rand_word(), 2'($urandom));
                for (int k = 0; k < CAPACITY + 3; k++)
                    plan_action(MODE_CREATE, 1'($urandom), 32'h4000_0000 + k * 7,
                                rand_word(), rand_word(), rand_rest_type());
                plan_action(MODE_CREATE, 1'($urandom), rand_id(), rand_word(),
                            rand_word(), OTYPE_IOC);
                void'(pick_resting(sd, id, pr, qt));
                plan_action(MODE_CREATE, sd, id, rand_word(), rand_word(), rand_rest_type());
                void'(pick_resting(sd, id, pr, qt));
                plan_action(MODE_DELETE, sd, id, rand_word(), rand_word(), 2'($urandom));
                plan_action(MODE_CREATE, 1'($urandom), rand_id(), rand_word(),
                            rand_word(), rand_rest_type());
            end else if (r < 35) begin
                plan_action(MODE_CREATE, 1'($urandom), rand_id(), rand_word(), rand_word(),
                            ($urandom_range(0, 7) == 0) ? OTYPE_IOC : rand_rest_type());
            end else if (r < 60) begin
                if ($urandom_range(0, 3) != 0 && pick_resting(sd, id, pr, qt)) begin
                    case ($urandom_range(0, 7))
                        6:       pr = pr ^ (32'h1 << $urandom_range(0, 31));
                        7:       qt = $urandom_range(32'hFFFF_FFFF, qt);
                        default: qt = (qt == 0) ? 32'h0 : $urandom_range(0, qt - 1);
                    endcase
                    plan_action(MODE_MODIFY, sd, id, pr, qt, 2'($urandom));
                end else begin
                    plan_action(MODE_MODIFY, 1'($urandom), rand_id(), rand_word(),
                                rand_word(), 2'($urandom));
                end
            end else if (r < 80) begin
                if ($urandom_range(0, 3) != 0 && pick_resting(sd, id, pr, qt))
                    plan_action(MODE_DELETE, sd, id, rand_word(), rand_word(), 2'($urandom));
                else
                    plan_action(MODE_DELETE, 1'($urandom), rand_id(), rand_word(),
                                rand_word(), 2'($urandom));
            end else if (r < 82) begin
                plan_action(MODE_CLEAR, 1'($urandom), $urandom(), $urandom(), $urandom(),
                            2'($urandom));
            end else begin
                // Noise: every field fully random.
                plan_action(t_mode'($urandom_range(0, 3)), 1'($urandom), $urandom(),
                            $urandom(), $urandom(), 2'($urandom));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (action_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (report_q.size() != 0)
            @(posedge i_clk);
        // Give a stray extra result time to show up.
        repeat (100) @(posedge i_clk);

        if (n_fail == 0 && report_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", report_q.size());
        $display("FAIL");
        $finish;
    end

    // Sender. An accepted item is run through the book copy at once, so the
    // expectation queue stays in acceptance order. A stalled item is held
    // unchanged; otherwise the next one is offered unless the current burst
    // has ended and a gap is running, or the next item waits for a drain.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 30);
            gap_left   = 0;
            for (int i = 0; i < CAPACITY; i++)
                book_valid[i] = 1'b0;
        end else begin
            still_offered = i_valid && o_stall;
            if (i_valid && !o_stall)
                report_q.push_back(book_apply(book_valid, book_entry, i_data));
            if (!still_offered) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (action_q.size() == 0
                        || (action_q[0].wait_empty && report_q.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    next_action = action_q.pop_front();
                    i_data  <= next_action.item;
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // Receiver. Stalls in phases of random length, each with its own stall
    // rate, some with none at all. Once, after 150 results, it holds off so
    // that the output register fills and the block has to stall its input
    // while the sender keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && n_results >= 150) begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(10, 200);
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        default: stall_pct = 75;
                    endcase
                end
                phase_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest
    // expectation; a result with nothing expected is a failure of its own.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (report_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result %0d: %p", n_results, o_data);
            end else begin
                want = report_q.pop_front();
                check_field("status",       32'(want.status),       32'(o_data.status));
                check_field("bid_present",  32'(want.bid_present),  32'(o_data.bid_present));
                check_field("best_bid",     want.best_bid,          o_data.best_bid);
                check_field("ask_present",  32'(want.ask_present),  32'(o_data.ask_present));
                check_field("best_ask",     want.best_ask,          o_data.best_ask);
                check_field("bids_removed", 32'(want.bids_removed), 32'(o_data.bids_removed));
                check_field("asks_removed", 32'(want.asks_removed), 32'(o_data.asks_removed));
            end
            n_results <= n_results + 1;
        end
    end

endmodule

// ----- files.f -----
rtl/core/lobt_pkg.sv
rtl/core/lobt_scan.sv
rtl/core/limit_order_book_table_core.sv
tb/sv/limit_order_book_table_core_tb.sv
